// ----- hw/rtl/aesrt_pkg.sv -----
// Package: AES round transform constants, S-box tables and GF(2^8) helpers.
`default_nettype none
package aesrt_pkg;

  localparam int unsigned NumBytes = 16;
  localparam int unsigned NumCols  = 4;

  typedef enum logic [2:0] {
    OP_ADD_KEY   = 3'd0,
    OP_ENC_ROUND = 3'd1,
    OP_ENC_FINAL = 3'd2,
    OP_DEC_ROUND = 3'd3,
    OP_DEC_FINAL = 3'd4
  } aesrt_op_e;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] col_t;

  typedef struct packed {
    logic enc;
    logic dec;
    logic fwd_mix;
    logic inv_mix;
  } aesrt_ctrl_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic byte_t xtime(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/aes_round_transform_top.sv -----
// Top level: one AES round step per item with a skid-buffered output.
// One item enters per cycle while in_stall_o is low; its result is registered.
// Sixteen S-box lanes and four column lanes run side by side in a single
// combinational round between the input and the output register; a second
// skid register lets an item be taken while a result waits to be taken.
`default_nettype none
module aes_round_transform_top import aesrt_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  op_i,
  input  wire  [63:0] state_hi_i,
  input  wire  [63:0] state_lo_i,
  input  wire  [63:0] key_hi_i,
  input  wire  [63:0] key_lo_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [63:0] result_hi_o,
  output logic [63:0] result_lo_o
);
  aesrt_ctrl_t ctrl;
  logic [127:0] st, ky, shifted, subbed, keyed, mixed;
  byte_t sb_in [NumBytes];
  byte_t sb_out [NumBytes];

  always_comb begin
    ctrl = '0;
    case (aesrt_op_e'(op_i))
      OP_ENC_ROUND: begin ctrl.enc = 1'b1; ctrl.fwd_mix = 1'b1; end
      OP_ENC_FINAL: begin ctrl.enc = 1'b1; end
      OP_DEC_ROUND: begin ctrl.dec = 1'b1; ctrl.inv_mix = 1'b1; end
      OP_DEC_FINAL: begin ctrl.dec = 1'b1; end
      default: ctrl = '0;
    endcase
  end

  assign st = {state_hi_i, state_lo_i};
  assign ky = {key_hi_i, key_lo_i};

  // byte k at bits 127-8k; sub then shift equals shift then sub (bytewise)
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb_in[c*4+r] = st[127-8*(c*4+r) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctrl.enc) begin
          shifted[127-8*(c*4+r) -: 8] = sb_out[((c+r)%4)*4+r];
        end else if (ctrl.dec) begin
          shifted[127-8*(c*4+r) -: 8] = sb_out[((c+4-r)%4)*4+r];
        end else begin
          shifted[127-8*(c*4+r) -: 8] = sb_out[c*4+r];
        end
      end
    end
  end

  for (genvar g = 0; g < NumBytes; g++) begin : g_sub
    aesrt_sub_lane u_sub (.byte_i(sb_in[g]), .ctrl_i(ctrl), .byte_o(sb_out[g]));
  end

  assign subbed = shifted;

  // fwd mix before key add; inverse mix after key add
  logic [127:0] mix_in;
  aesrt_ctrl_t  mix_ctrl;
  assign mix_in   = ctrl.fwd_mix ? subbed : (subbed ^ ky);
  assign mix_ctrl = ctrl;
  for (genvar g = 0; g < NumCols; g++) begin : g_mix
    aesrt_mix_lane u_mix (
      .col_i (mix_in[127-32*g -: 32]),
      .ctrl_i(mix_ctrl),
      .col_o (mixed[127-32*g -: 32])
    );
  end
  assign keyed = ctrl.fwd_mix ? (mixed ^ ky) : mixed;

  logic         out_vld_q, skid_vld_q;
  logic [127:0] out_q, skid_q;

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign result_hi_o = out_q[127:64];
  assign result_lo_o = out_q[63:0];

  wire take_in = in_valid_i && !in_stall_o;
  wire out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q  <= skid_vld_q || take_in;
        skid_vld_q <= 1'b0;
      end else if (take_in) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : keyed;
    end else if (take_in) begin
      skid_q <= keyed;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/aesrt_sub_lane.sv -----
// Byte substitution lane: forward or inverse S-box for one state byte, or pass-through.
`default_nettype none
module aesrt_sub_lane import aesrt_pkg::*; (
  input  wire byte_t       byte_i,
  input  wire aesrt_ctrl_t ctrl_i,
  output byte_t            byte_o
);
  always_comb begin
    if (ctrl_i.enc) begin
      byte_o = SBOX[byte_i];
    end else if (ctrl_i.dec) begin
      byte_o = INV_SBOX[byte_i];
    end else begin
      byte_o = byte_i;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/aesrt_mix_lane.sv -----
// Column lane: forward or inverse MixColumns on one 32-bit column, or pass-through.
`default_nettype none
module aesrt_mix_lane import aesrt_pkg::*; (
  input  wire col_t        col_i,
  input  wire aesrt_ctrl_t ctrl_i,
  output col_t             col_o
);
  byte_t b [4];
  byte_t x2 [4];
  byte_t x4 [4];
  byte_t x8 [4];
  byte_t m2 [4];
  byte_t m3 [4];
  byte_t m9 [4];
  byte_t mb [4];
  byte_t md [4];
  byte_t me [4];
  byte_t r [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b[k]  = col_i[31-8*k -: 8];
      x2[k] = xtime(b[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m2[k] = x2[k];
      m3[k] = x2[k] ^ b[k];
      m9[k] = x8[k] ^ b[k];
      mb[k] = x8[k] ^ x2[k] ^ b[k];
      md[k] = x8[k] ^ x4[k] ^ b[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int i = 0; i < 4; i++) begin
      if (ctrl_i.fwd_mix) begin
        r[i] = m2[i] ^ m3[(i+1)%4] ^ b[(i+2)%4] ^ b[(i+3)%4];
      end else if (ctrl_i.inv_mix) begin
        r[i] = me[i] ^ mb[(i+1)%4] ^ md[(i+2)%4] ^ m9[(i+3)%4];
      end else begin
        r[i] = b[i];
      end
      col_o[31-8*i -: 8] = r[i];
    end
  end
endmodule
`default_nettype wire
